// ===== rtl/core/c_string_literal_unescape_macros.svh =====
// Assertion macros for the unescape block.
`ifndef C_STRING_LITERAL_UNESCAPE_MACROS_SVH
`define C_STRING_LITERAL_UNESCAPE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CSU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("csu assertion failed");

`define CSU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("csu assertion failed");

`else

`define CSU_ASSERT(label, clk, rst, prop)

`define CSU_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/csu_pkg.sv =====
package csu_pkg;

   typedef enum logic [9:0] {
      M_IDLE  = 10'b00_0000_0001,
      M_BODY  = 10'b00_0000_0010,
      M_ESC   = 10'b00_0000_0100,
      M_HEX   = 10'b00_0000_1000,
      M_OCT   = 10'b00_0001_0000,
      M_U4    = 10'b00_0010_0000,
      M_U8    = 10'b00_0100_0000,
      M_SBS   = 10'b00_1000_0000,
      M_SU    = 10'b01_0000_0000,
      M_U4LOW = 10'b10_0000_0000
   } mode_type;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_OPEN   = 3'd1;
   localparam logic [2:0] ERR_UNTERM = 3'd2;
   localparam logic [2:0] ERR_UNIV   = 3'd3;
   localparam logic [2:0] ERR_SURR   = 3'd4;
   localparam logic [2:0] ERR_RANGE  = 3'd5;

   localparam logic [1:0] CSR_DELIMITER = 2'd0;
   localparam logic [1:0] CSR_CHECK_END = 2'd1;
   localparam logic [1:0] CSR_UNICODE   = 2'd2;

   localparam int MAX_RES = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] error_code;
   } res_type;

   typedef struct packed {
      logic [2:0]                  cnt;
      res_type [MAX_RES-1:0]       res;
   } grp_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] acc;
      logic [3:0]  dcnt;
      logic [9:0]  hs;
   } st_type;

   typedef struct packed {
      logic [7:0] delimiter;
      logic       check_end;
      logic       unicode_escapes;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic free;
   } buf_ctl_type;

   function automatic res_type data_res(input logic [7:0] b);
      res_type r;
      r.kind       = KIND_DATA;
      r.out_byte   = b;
      r.error_code = ERR_NONE;
      return r;
   endfunction

   function automatic res_type mark_res(input logic [1:0] k, input logic [2:0] e);
      res_type r;
      r.kind       = k;
      r.out_byte   = 8'h00;
      r.error_code = e;
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   function automatic grp_type utf8_enc(input logic [31:0] cp);
      grp_type g;
      g = '0;
      if (cp < 32'h80) begin
         g.cnt    = 3'd1;
         g.res[0] = data_res(cp[7:0]);
      end else if (cp < 32'h800) begin
         g.cnt    = 3'd2;
         g.res[0] = data_res({3'b110, cp[10:6]});
         g.res[1] = data_res({2'b10, cp[5:0]});
      end else if (cp[31:8] == 24'h0000EE) begin
         g.cnt    = 3'd1;
         g.res[0] = data_res(cp[7:0]);
      end else if (cp < 32'h10000) begin
         g.cnt    = 3'd3;
         g.res[0] = data_res({4'hE, cp[15:12]});
         g.res[1] = data_res({2'b10, cp[11:6]});
         g.res[2] = data_res({2'b10, cp[5:0]});
      end else if (cp < 32'h110000) begin
         g.cnt    = 3'd4;
         g.res[0] = data_res({5'b11110, cp[20:18]});
         g.res[1] = data_res({2'b10, cp[17:12]});
         g.res[2] = data_res({2'b10, cp[11:6]});
         g.res[3] = data_res({2'b10, cp[5:0]});
      end
      return g;
   endfunction

endpackage

// ===== rtl/core/csu_if.sv =====
interface csu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface csu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [2:0] error_code;
   logic       last;

   modport source (output valid, output kind, output out_byte, output error_code,
                   output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input error_code,
                   input last, output ready);
endinterface

interface csu_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/csu_decode.sv =====
module csu_decode (
   input  csu_pkg::st_type  st,
   input  csu_pkg::cfg_type cfg,
   input  logic [7:0]       in_byte,
   output csu_pkg::st_type  st_next,
   output csu_pkg::grp_type grp
);

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_UP_U   = 8'h55;
   localparam logic [7:0] CH_X      = 8'h78;

   typedef struct packed {
      logic              has;
      csu_pkg::res_type  res;
      csu_pkg::mode_type mode;
   } body_type;

   function automatic body_type body_step(input logic [7:0] b, input csu_pkg::cfg_type c);
      body_type r;
      r.has  = 1'b1;
      r.mode = csu_pkg::M_BODY;
      r.res  = csu_pkg::data_res(b);
      if (b == c.delimiter) begin
         r.res  = csu_pkg::mark_res(csu_pkg::KIND_END, csu_pkg::ERR_NONE);
         r.mode = csu_pkg::M_IDLE;
      end else if (b == CH_BSLASH) begin
         r.has  = 1'b0;
         r.mode = csu_pkg::M_ESC;
      end else if (b < 8'h20 && b != CH_TAB) begin
         if (c.check_end) begin
            r.res  = csu_pkg::mark_res(csu_pkg::KIND_ERR, csu_pkg::ERR_UNTERM);
            r.mode = csu_pkg::M_IDLE;
         end else if (b == 8'h00) begin
            r.res  = csu_pkg::mark_res(csu_pkg::KIND_END, csu_pkg::ERR_NONE);
            r.mode = csu_pkg::M_IDLE;
         end
      end
      return r;
   endfunction

   logic [4:0]  hx;
   logic [31:0] acc_sh;
   logic [31:0] acc_oct;
   logic [31:0] pair_cp;
   logic [3:0]  dnx;
   logic        is_oct;
   body_type    bd;

   always_comb begin
      st_next = st;
      grp     = '0;
      hx      = csu_pkg::hex_digit(in_byte);
      acc_sh  = {st.acc[27:0], 4'b0000} + {28'd0, hx[3:0]};
      acc_oct = {st.acc[28:0], 3'b000} + {29'd0, in_byte[2:0]};
      pair_cp = {12'd0, st.hs, acc_sh[9:0]} + 32'h10000;
      dnx     = st.dcnt + 4'd1;
      is_oct  = (in_byte[7:3] == 5'b00110);
      bd      = body_step(in_byte, cfg);

      case (st.mode)
         csu_pkg::M_IDLE: begin
            if (in_byte == cfg.delimiter) begin
               st_next.mode = csu_pkg::M_BODY;
            end else begin
               grp.cnt    = 3'd1;
               grp.res[0] = csu_pkg::mark_res(csu_pkg::KIND_ERR, csu_pkg::ERR_OPEN);
            end
         end
         csu_pkg::M_BODY: begin
            st_next.mode = bd.mode;
            grp.cnt      = {2'b00, bd.has};
            grp.res[0]   = bd.res;
         end
         csu_pkg::M_ESC: begin
            st_next.mode = csu_pkg::M_BODY;
            grp.cnt      = 3'd1;
            grp.res[0]   = csu_pkg::data_res(in_byte);
            case (in_byte)
               8'h61: grp.res[0] = csu_pkg::data_res(8'h07);
               8'h62: grp.res[0] = csu_pkg::data_res(8'h08);
               8'h74: grp.res[0] = csu_pkg::data_res(8'h09);
               8'h76: grp.res[0] = csu_pkg::data_res(8'h0B);
               8'h6E: grp.res[0] = csu_pkg::data_res(8'h0A);
               8'h72: grp.res[0] = csu_pkg::data_res(8'h0D);
               8'h66: grp.res[0] = csu_pkg::data_res(8'h0C);
               CH_X: begin
                  grp.cnt      = 3'd0;
                  st_next.acc  = 32'd0;
                  st_next.dcnt = 4'd0;
                  st_next.mode = csu_pkg::M_HEX;
               end
               CH_LOW_U, CH_UP_U: begin
                  if (cfg.unicode_escapes) begin
                     grp.cnt      = 3'd0;
                     st_next.acc  = 32'd0;
                     st_next.dcnt = 4'd0;
                     st_next.mode = (in_byte == CH_LOW_U) ? csu_pkg::M_U4 : csu_pkg::M_U8;
                  end
               end
               default: begin
                  if (is_oct) begin
                     grp.cnt      = 3'd0;
                     st_next.acc  = {29'd0, in_byte[2:0]};
                     st_next.dcnt = 4'd1;
                     st_next.mode = csu_pkg::M_OCT;
                  end
               end
            endcase
         end
         csu_pkg::M_HEX: begin
            if (hx[4]) begin
               st_next.acc = acc_sh;
            end else begin
               st_next.mode = bd.mode;
               grp.cnt      = {2'b00, bd.has} + 3'd1;
               grp.res[0]   = csu_pkg::data_res(st.acc[7:0]);
               grp.res[1]   = bd.res;
            end
         end
         csu_pkg::M_OCT: begin
            if (is_oct) begin
               st_next.acc  = acc_oct;
               st_next.dcnt = dnx;
               if (dnx >= 4'd3) begin
                  st_next.mode = csu_pkg::M_BODY;
                  grp.cnt      = 3'd1;
                  grp.res[0]   = csu_pkg::data_res(acc_oct[7:0]);
               end
            end else begin
               st_next.mode = bd.mode;
               grp.cnt      = {2'b00, bd.has} + 3'd1;
               grp.res[0]   = csu_pkg::data_res(st.acc[7:0]);
               grp.res[1]   = bd.res;
            end
         end
         csu_pkg::M_U4, csu_pkg::M_U8, csu_pkg::M_U4LOW: begin
            if (!hx[4]) begin
               st_next.mode = csu_pkg::M_IDLE;
               grp.cnt      = 3'd1;
               grp.res[0]   = csu_pkg::mark_res(csu_pkg::KIND_ERR, csu_pkg::ERR_UNIV);
            end else begin
               st_next.acc  = acc_sh;
               st_next.dcnt = dnx;
               if (st.mode == csu_pkg::M_U8) begin
                  if (dnx >= 4'd8) begin
                     if (acc_sh > 32'h10FFFF) begin
                        st_next.mode = csu_pkg::M_IDLE;
                        grp.cnt      = 3'd1;
                        grp.res[0]   = csu_pkg::mark_res(csu_pkg::KIND_ERR,
                                                         csu_pkg::ERR_RANGE);
                     end else begin
                        st_next.mode = csu_pkg::M_BODY;
                        grp          = csu_pkg::utf8_enc(acc_sh);
                     end
                  end
               end else if (dnx >= 4'd4) begin
                  if (st.mode == csu_pkg::M_U4) begin
                     if (acc_sh >= 32'hD800 && acc_sh <= 32'hDBFF) begin
                        st_next.hs   = acc_sh[9:0];
                        st_next.mode = csu_pkg::M_SBS;
                     end else begin
                        st_next.mode = csu_pkg::M_BODY;
                        grp          = csu_pkg::utf8_enc(acc_sh);
                     end
                  end else if (acc_sh >= 32'hDC00 && acc_sh <= 32'hDFFF) begin
                     st_next.mode = csu_pkg::M_BODY;
                     grp          = csu_pkg::utf8_enc(pair_cp);
                  end else begin
                     st_next.mode = csu_pkg::M_IDLE;
                     grp.cnt      = 3'd1;
                     grp.res[0]   = csu_pkg::mark_res(csu_pkg::KIND_ERR,
                                                      csu_pkg::ERR_SURR);
                  end
               end
            end
         end
         csu_pkg::M_SBS: begin
            if (in_byte == CH_BSLASH) begin
               st_next.mode = csu_pkg::M_SU;
            end else begin
               st_next.mode = csu_pkg::M_IDLE;
               grp.cnt      = 3'd1;
               grp.res[0]   = csu_pkg::mark_res(csu_pkg::KIND_ERR, csu_pkg::ERR_SURR);
            end
         end
         csu_pkg::M_SU: begin
            if (in_byte == CH_LOW_U) begin
               st_next.acc  = 32'd0;
               st_next.dcnt = 4'd0;
               st_next.mode = csu_pkg::M_U4LOW;
            end else begin
               st_next.mode = csu_pkg::M_IDLE;
               grp.cnt      = 3'd1;
               grp.res[0]   = csu_pkg::mark_res(csu_pkg::KIND_ERR, csu_pkg::ERR_SURR);
            end
         end
         default: begin
            st_next.mode = csu_pkg::M_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/csu_out_buf.sv =====
module csu_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  csu_pkg::grp_type     grp,
   input  logic                 load,
   output logic                 free,
   csu_rsp_if.source            rsp_ch
);

   csu_pkg::res_type [csu_pkg::MAX_RES-1:0] ents_ff, ents_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       is_last;
   logic       xfer;

   assign is_last = ({1'b0, idx_ff} == (cnt_ff - 3'd1));
   assign xfer    = rsp_ch.valid && rsp_ch.ready;
   assign free    = (cnt_ff == 3'd0) || (xfer && is_last);

   assign rsp_ch.valid      = (cnt_ff != 3'd0);
   assign rsp_ch.kind       = ents_ff[idx_ff].kind;
   assign rsp_ch.out_byte   = ents_ff[idx_ff].out_byte;
   assign rsp_ch.error_code = ents_ff[idx_ff].error_code;
   assign rsp_ch.last       = is_last;

   always_comb begin
      ents_in = ents_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      if (load) begin
         ents_in = grp.res;
         cnt_in  = grp.cnt;
         idx_in  = 2'd0;
      end else if (xfer) begin
         if (is_last) begin
            cnt_in = 3'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ents_ff <= ents_in;
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== rtl/core/c_string_literal_unescape.sv =====
// Decodes a quoted C string literal one source byte per transaction on req_ch and emits
// decoded bytes, an end marker or an error on rsp_ch; rsp last flags the final result of
// each source byte. A byte enters every cycle when each byte yields at most one result and
// rsp_ch is ready; a byte yielding k results (UTF-8 sequences up to 4 bytes, a hex or octal value
// followed by its terminating byte) holds the input side until all k are taken from the
// single-entry result group register, which drains one result per cycle while rsp_ch is ready.
// A byte passes the input register and then the result register before its first rsp. csr_ch
// writes delimiter (index 0), check_end (1) and unicode_escapes (2), the delimiter in bits [7:0]
// and the flags in bit 0; it is always ready and is to be written only while the block is idle.
module c_string_literal_unescape (
   input  logic         clock,
   input  logic         reset,
   csu_req_if.sink      req_ch,
   csu_rsp_if.source    rsp_ch,
   csu_csr_if.sink      csr_ch
);

`include "c_string_literal_unescape_macros.svh"

   csu_pkg::cfg_type     cfg_ff, cfg_in;
   csu_pkg::st_type      st_ff, st_in, st_next;
   csu_pkg::grp_type     dec_grp;
   csu_pkg::buf_ctl_type bctl;
   logic [7:0] byte_ff, byte_in;
   logic       in_vld_ff, in_vld_in;
   logic       adv;

   csu_decode u_decode (
      .st      (st_ff),
      .cfg     (cfg_ff),
      .in_byte (byte_ff),
      .st_next (st_next),
      .grp     (dec_grp)
   );

   csu_out_buf u_out_buf (
      .clock  (clock),
      .reset  (reset),
      .grp    (dec_grp),
      .load   (bctl.load),
      .free   (bctl.free),
      .rsp_ch (rsp_ch)
   );

   assign adv          = in_vld_ff && ((dec_grp.cnt == 3'd0) || bctl.free);
   assign bctl.load    = adv && (dec_grp.cnt != 3'd0);
   assign req_ch.ready = !in_vld_ff || adv;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            csu_pkg::CSR_DELIMITER: cfg_in.delimiter       = csr_ch.data;
            csu_pkg::CSR_CHECK_END: cfg_in.check_end       = csr_ch.data[0];
            csu_pkg::CSR_UNICODE:   cfg_in.unicode_escapes = csr_ch.data[0];
            default:                cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_comb begin
      st_in     = adv ? st_next : st_ff;
      in_vld_in = in_vld_ff;
      byte_in   = byte_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_vld_in = 1'b1;
         byte_in   = req_ch.in_byte;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         cfg_ff.delimiter       <= 8'd34;
         cfg_ff.check_end       <= 1'b1;
         cfg_ff.unicode_escapes <= 1'b1;
         st_ff.mode             <= csu_pkg::M_IDLE;
         st_ff.acc              <= 32'd0;
         st_ff.dcnt             <= 4'd0;
         st_ff.hs               <= 10'd0;
         in_vld_ff              <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         st_ff     <= st_in;
         in_vld_ff <= in_vld_in;
      end
   end

   `CSU_ASSERT(a_mark_byte_zero, clock, reset, (rsp_ch.valid && rsp_ch.kind != csu_pkg::KIND_DATA) |-> (rsp_ch.out_byte == 8'h00))
   `CSU_ASSERT(a_err_code_kind, clock, reset, rsp_ch.valid |-> ((rsp_ch.kind == csu_pkg::KIND_ERR) == (rsp_ch.error_code != csu_pkg::ERR_NONE)))
   `CSU_ASSERT(a_err_to_idle, clock, reset, (adv && dec_grp.cnt == 3'd1 && dec_grp.res[0].kind == csu_pkg::KIND_ERR) |=> (st_ff.mode == csu_pkg::M_IDLE))

endmodule
